// ----- rtl/eca_pkg.sv -----
// ----------------------------------------------------------------------------
// eca_pkg: shared types and constants
// Item modes, controller states and the command group that passes from the
// controller to the datapath of the cellular automaton ring.
// ----------------------------------------------------------------------------
package eca_pkg;

    localparam int MODE_W  = 3;
    localparam int INDEX_W = 7;
    localparam int RULE_W  = 8;

    localparam logic [RULE_W-1:0] RULE_RESET = 8'd15;

    // Item modes; codes above MODE_READ act as a read
    typedef enum logic [MODE_W-1:0] {
        MODE_ADVANCE = 3'd0,
        MODE_TOGGLE  = 3'd1,
        MODE_SEED    = 3'd2,
        MODE_WRITE   = 3'd3,
        MODE_READ    = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_READ = 2'd2,
        ST_SEND = 2'd3
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // capture the accepted item
        logic exec;    // apply the operation to the ring
        logic read;    // register the indexed cell
    } cmd_t;

endpackage

// ----- rtl/eca_ctrl.sv -----
// ----------------------------------------------------------------------------
// eca_ctrl: item sequencer
// Steps each item through capture, execute, read-back and delivery.
// ----------------------------------------------------------------------------
module eca_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          out_ready,
    output logic          in_ready,
    output logic          out_valid,
    output eca_pkg::cmd_t cmd
);
    import eca_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/eca_datapath.sv -----
// ----------------------------------------------------------------------------
// eca_datapath: cell ring and rule register
// Holds the ring, applies one operation on command and reads back one cell.
// ----------------------------------------------------------------------------
module eca_datapath
#(
    parameter int CELLS = 128
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  eca_pkg::cmd_t                 cmd,
    input  logic [eca_pkg::MODE_W-1:0]    in_mode,
    input  logic [eca_pkg::INDEX_W-1:0]   in_index,
    input  logic                          in_value,
    input  logic                          rule_we,
    input  logic [eca_pkg::RULE_W-1:0]    rule_wdata,
    output logic                          cell_value
);
    import eca_pkg::*;

    localparam int CW = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam logic [CW-1:0] CENTER = CW'(CELLS / 2);

    logic [MODE_W-1:0]  mode_reg;
    logic [INDEX_W-1:0] index_reg;
    logic               value_reg;
    logic [RULE_W-1:0]  rule_reg;
    logic [CELLS-1:0]   cells_reg;
    logic [CELLS-1:0]   cells_next;
    logic [CELLS-1:0]   gen_next;
    logic               result_reg;
    logic [CW-1:0]      cidx;
    logic               in_ring;

    assign cidx    = CW'(index_reg);
    assign in_ring = ({{(32 - INDEX_W){1'b0}}, index_reg} < 32'(CELLS));

    // Next generation, neighbors wrap around the ring
    for (genvar i = 0; i < CELLS; i++)
    begin : g_cell
        logic [2:0] pat;
        assign pat = {cells_reg[(i + CELLS - 1) % CELLS], cells_reg[i],
                      cells_reg[(i + 1) % CELLS]};
        assign gen_next[i] = rule_reg[pat];
    end

    always_comb
    begin
        cells_next = cells_reg;
        unique case (mode_reg)
            MODE_ADVANCE:
            begin
                cells_next = gen_next;
            end
            MODE_TOGGLE:
            begin
                if (in_ring)
                begin
                    cells_next[cidx] = ~cells_reg[cidx];
                end
            end
            MODE_SEED:
            begin
                cells_next         = '0;
                cells_next[CENTER] = 1'b1;
            end
            MODE_WRITE:
            begin
                if (in_ring)
                begin
                    cells_next[cidx] = value_reg;
                end
            end
            default:
            begin
                cells_next = cells_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg  <= in_mode;
            index_reg <= in_index;
            value_reg <= in_value;
        end
        if (cmd.read)
        begin
            result_reg <= in_ring ? cells_reg[cidx] : 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells_reg <= '0;
            rule_reg  <= RULE_RESET;
        end
        else
        begin
            if (cmd.exec)
            begin
                cells_reg <= cells_next;
            end
            if (rule_we)
            begin
                rule_reg <= rule_wdata;
            end
        end
    end

    assign cell_value = result_reg;

endmodule

// ----- rtl/elementary_cellular_automaton_ring_top.sv -----
// ----------------------------------------------------------------------------
// elementary_cellular_automaton_ring_top: Wolfram rule ring automaton
// Ring of one-bit cells with advance, toggle, seed, write and read items.
// ----------------------------------------------------------------------------
// Sequence: after the input transaction the controller steps through capture,
//   execute and read-back before the result is valid on m_tvalid.
// Flow: the next item is taken only once the result transaction completes,
//   so one item is in flight at a time.
// Reset: rst_n asynchronous active low; ring all zero, rule 15, block idle.
// ----------------------------------------------------------------------------
module elementary_cellular_automaton_ring_top
#(
    parameter int CELLS = 128
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [2:0] mode, [9:3] index, [10] value, [15:11] zero
    // Results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [0] cell_value, [7:1] zero
    // Rule register write
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data
);
    import eca_pkg::*;

    cmd_t cmd;
    logic cell_value;

    // Sequence each item: capture, apply, read back, then hold the result
    eca_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .out_ready (m_tready),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .cmd       (cmd)
    );

    // Ring storage, rule register and per-cell next-generation logic
    eca_datapath #(.CELLS(CELLS)) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_mode    (s_tdata[2:0]),
        .in_index   (s_tdata[9:3]),
        .in_value   (s_tdata[10]),
        .rule_we    (cfg_wr_en),
        .rule_wdata (cfg_wr_data),
        .cell_value (cell_value)
    );

    // Pad the single result bit to a whole byte
    assign m_tdata = {7'b0, cell_value};

endmodule

// ----- rtl/eca_checker.sv -----
// ----------------------------------------------------------------------------
// eca_checker: port-level checks for the automaton ring
// Watches the stream handshakes of the top level over time.
// ----------------------------------------------------------------------------
module eca_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // One item in flight: no input taken while a result is pending
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while result pending");

    // Every input transaction yields a result after execute and read-back
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> ##3 m_tvalid)
        else $error("result missing after input transaction");

    // Result padding bits stay zero
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7:1] == 7'b0)
        else $error("result padding not zero");

endmodule

bind elementary_cellular_automaton_ring_top eca_checker u_eca_checker (.*);

// ----- tb/eca_ring_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eca_ring_checker: result checker for the cellular automaton ring
// Watches the item, result and rule channels, keeps a copy of the ring and the
// rule, predicts the cell value of every accepted item and compares it with
// the result transactions in order.
// ----------------------------------------------------------------------------
module eca_ring_checker
#(
    parameter int CELLS = 128
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,    // [2:0] mode, [9:3] index, [10] value, [15:11] zero
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,    // [0] cell_value, [7:1] zero
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    output int          fail_count,
    output int          pending
);
    import eca_pkg::*;

    logic [CELLS-1:0]   ring_copy;
    logic [RULE_W-1:0]  rule_copy;
    logic [7:0]         cell_expect_q[$];
    logic [7:0]         cell_expected;
    logic [MODE_W-1:0]  item_mode;
    logic [INDEX_W-1:0] item_index;
    logic               item_value;
    int                 mismatches;

    // One generation: each cell looks up its neighborhood in the rule
    function automatic logic [CELLS-1:0] next_generation(input logic [CELLS-1:0] cur,
                                                         input logic [RULE_W-1:0] rule_bits);
        logic [CELLS-1:0] nxt;
        int               left;
        int               right;
        logic [2:0]       pattern;
        for (int i = 0; i < CELLS; i++)
        begin
            left    = (i == 0) ? CELLS - 1 : i - 1;
            right   = (i == CELLS - 1) ? 0 : i + 1;
            pattern = {cur[left], cur[i], cur[right]};
            nxt[i]  = rule_bits[pattern];
        end
        return nxt;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_copy = '0;
            rule_copy = RULE_RESET;
            cell_expect_q.delete();
            mismatches = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                rule_copy = cfg_wr_data;

            // Compare first so a result never meets the expectation of its own edge
            if (m_tvalid && m_tready)
            begin
                if (cell_expect_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                    mismatches++;
                end
                else
                begin
                    cell_expected = cell_expect_q.pop_front();
                    if (m_tdata !== cell_expected)
                    begin
                        $display("%0t: cell value mismatch, expected %h, actual %h",
                                 $time, cell_expected, m_tdata);
                        mismatches++;
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                item_mode  = s_tdata[2:0];
                item_index = s_tdata[9:3];
                item_value = s_tdata[10];
                case (item_mode)
                    MODE_ADVANCE: ring_copy = next_generation(ring_copy, rule_copy);
                    MODE_TOGGLE:
                        if (item_index < CELLS)
                            ring_copy[item_index] = ~ring_copy[item_index];
                    MODE_SEED:
                    begin
                        ring_copy = '0;
                        ring_copy[CELLS/2] = 1'b1;
                    end
                    MODE_WRITE:
                        if (item_index < CELLS)
                            ring_copy[item_index] = item_value;
                    default: ;
                endcase
                cell_expect_q.push_back({7'd0,
                                         (item_index < CELLS) ? ring_copy[item_index] : 1'b0});
            end

            fail_count <= mismatches;
            pending    <= cell_expect_q.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the elementary cellular automaton ring
// Drives directed and random items through the stream input under random
// gaps and back-pressure, changes the rule between phases while the block is
// idle, and reports the verdict of the ring checker.
// ----------------------------------------------------------------------------
module tb_top;
    import eca_pkg::*;

    localparam int CELLS       = 128;
    localparam int CLK_HALF    = 4;
    localparam int LONG_HOLD   = 64;      // receiver hold-off, in cycles
    localparam int SETTLE      = 6;       // a margin beyond the result latency
    localparam int PHASE_ITEMS = 50;
    localparam int CYCLE_LIMIT = 200000;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata     = '0;        // [2:0] mode, [9:3] index, [10] value, [15:11] zero
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [7:0]  m_tdata;                 // [0] cell_value, [7:1] zero
    logic        cfg_wr_en   = 1'b0;
    logic [7:0]  cfg_wr_data = '0;

    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    bit          quiet         = 1'b0;    // no gaps on either side while set
    bit          long_hold_req = 1'b0;    // ask the receiver for one long hold-off

    logic [7:0]  rule_list [9];

    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    elementary_cellular_automaton_ring_top #(
        .CELLS (CELLS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    eca_ring_checker #(
        .CELLS (CELLS)
    ) ring_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // Gap in cycles before the next item or the next ready window
    function automatic int draw_gap();
        if (quiet)
            return 0;
        return $urandom_range(0, 4);
    endfunction

    // Offer one item and hold it until the transaction completes. Valid is
    // lowered only when a gap follows, so back-to-back items keep it high.
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [INDEX_W-1:0] index,
                             input logic value, input int gap);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, value, index, mode};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Random item, weighted toward advances, writes and reads; unused codes too
    task automatic send_random(input int gap);
        int                pick;
        logic [MODE_W-1:0] mode;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            mode = MODE_ADVANCE;
        else if (pick < 45)
            mode = MODE_TOGGLE;
        else if (pick < 50)
            mode = MODE_SEED;
        else if (pick < 72)
            mode = MODE_WRITE;
        else if (pick < 92)
            mode = MODE_READ;
        else
            mode = MODE_W'($urandom_range(MODE_READ + 1, 7));
        send_item(mode, INDEX_W'($urandom_range(0, CELLS - 1)), 1'($urandom_range(0, 1)), gap);
    endtask

    // Drop valid in the step of the last transaction, then hold until every
    // expected result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Write the rule only while the block is idle
    task automatic set_rule(input logic [RULE_W-1:0] rule_value);
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= rule_value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // One rule setting: start from a center seed or a random pattern, then
    // run a random mix of operations on it
    task automatic run_phase(input logic [RULE_W-1:0] rule_value, input int items);
        set_rule(rule_value);
        quiet = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 1))
            send_item(MODE_SEED, INDEX_W'($urandom_range(0, CELLS - 1)), 1'b0, draw_gap());
        else
            repeat (12) send_item(MODE_WRITE, INDEX_W'($urandom_range(0, CELLS - 1)),
                                  1'($urandom_range(0, 1)), draw_gap());
        repeat (items)
            send_random(draw_gap());
        quiet = 1'b0;
    endtask

    // Stimulus
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items under the reset rule (next cell = not left neighbor)
        send_item(MODE_READ,    7'd0,   1'b0, draw_gap());
        send_item(MODE_READ,    7'd127, 1'b0, draw_gap());
        send_item(MODE_WRITE,   7'd0,   1'b1, draw_gap());
        send_item(MODE_WRITE,   7'd127, 1'b1, draw_gap());
        send_item(MODE_ADVANCE, 7'd0,   1'b0, draw_gap());   // left of cell 0 wraps to the end
        send_item(MODE_READ,    7'd127, 1'b0, draw_gap());
        send_item(MODE_READ,    7'd1,   1'b0, draw_gap());
        send_item(MODE_TOGGLE,  7'd127, 1'b0, draw_gap());
        send_item(MODE_TOGGLE,  7'd0,   1'b1, draw_gap());
        send_item(MODE_SEED,    7'd64,  1'b0, draw_gap());
        send_item(MODE_READ,    7'd63,  1'b0, draw_gap());
        send_item(3'd5,         7'd64,  1'b1, draw_gap());   // unused codes act as a read
        send_item(3'd6,         7'd0,   1'b1, draw_gap());
        send_item(3'd7,         7'd127, 1'b1, draw_gap());
        send_item(MODE_ADVANCE, 7'd64,  1'b0, draw_gap());
        send_item(MODE_ADVANCE, 7'd65,  1'b0, draw_gap());
        send_item(MODE_WRITE,   7'd64,  1'b0, draw_gap());
        send_item(MODE_WRITE,   7'd127, 1'b1, draw_gap());
        send_item(MODE_TOGGLE,  7'd127, 1'b1, draw_gap());
        send_item(MODE_SEED,    7'd0,   1'b0, draw_gap());
        send_item(MODE_ADVANCE, 7'd127, 1'b0, draw_gap());

        // Rule extremes first, then the usual interesting rules and two random ones
        rule_list = '{8'd0, 8'd255, 8'd30, 8'd90, 8'd110, 8'd184, 8'd150, 8'd0, 8'd0};
        rule_list[7] = 8'($urandom_range(0, 255));
        rule_list[8] = 8'($urandom_range(0, 255));

        for (int i = 0; i < 9; i++)
        begin
            run_phase(rule_list[i], PHASE_ITEMS);
            if (i == 1)
            begin
                // Stall the result side and keep offering: input must back up
                long_hold_req = 1'b1;
                repeat (16) send_random(0);
            end
            if (i == 3)
            begin
                // Pause the sender until the pipeline is empty, then resume
                wait_drained();
                repeat (10) send_random(draw_gap());
            end
        end

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Result side: random ready gaps, one long hold-off on request
    initial
    begin
        int gap;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                gap = draw_gap();
                if (gap > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    // Watchdog: abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule
